/* src/tbl_pkg.sv */
// tbl_pkg: shared types, constants, width tables and glyph mapping
// for the text block layout; no dependencies
package tbl_pkg;

  localparam int unsigned RegCount = 7;
  localparam int unsigned AddrWidth = 5;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_SLANT_DIV   = 3'd2;
  localparam logic [2:0] REG_FONT_NUMBER = 3'd3;
  localparam logic [2:0] REG_SMALL_FONT  = 3'd4;
  localparam logic [2:0] REG_LINE_HEIGHT = 3'd5;
  localparam logic [2:0] REG_PART_FILTER = 3'd6;

  localparam logic [7:0] CHAR_LEAD = 8'hC3;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_BAR  = 8'h7C;
  localparam logic signed [9:0] CHAR_ZERO = 10'sd48;
  localparam logic [4:0] PART_ALL  = 5'h1F;
  localparam logic [6:0] CODE_HIGH = 7'd1;
  localparam int unsigned AccentBase = 15;
  localparam int unsigned AccentCount = 15;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HELD  = 2'd1,
    PH_KEEP  = 2'd2,
    PH_SKIP  = 2'd3
  } tbl_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BODY,
    ST_DIV,
    ST_OUT,
    ST_FINISH
  } tbl_state_e;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] slant_divisor;
    logic [1:0]         font_number;
    logic               small_font;
    logic [7:0]         line_height;
    logic [4:0]         part_filter;
  } tbl_cfg_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic body;
    logic div_start;
    logic load_out;
    logic advance;
    logic finish;
  } tbl_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic emit;
    logic flat;
    logic more;
    logic div_done;
    logic out_taken;
  } tbl_sts_t;

  localparam logic [3:0] WIDE_ROM [128] = '{
    4'd9, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd8,
    4'd9, 4'd9, 4'd8, 4'd8, 4'd8, 4'd8, 4'd5, 4'd5,
    4'd8, 4'd8, 4'd8, 4'd9, 4'd8, 4'd8, 4'd10, 4'd10,
    4'd5, 4'd6, 4'd9, 4'd13, 4'd11, 4'd12, 4'd12, 4'd6,
    4'd6, 4'd6, 4'd12, 4'd12, 4'd5, 4'd9, 4'd6, 4'd9,
    4'd8, 4'd8, 4'd9, 4'd9, 4'd8, 4'd9, 4'd8, 4'd8,
    4'd9, 4'd9, 4'd6, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd12, 4'd8, 4'd9, 4'd9, 4'd9, 4'd8, 4'd8, 4'd8,
    4'd9, 4'd4, 4'd8, 4'd9, 4'd8, 4'd10, 4'd9, 4'd9,
    4'd8, 4'd9, 4'd8, 4'd9, 4'd10, 4'd8, 4'd9, 4'd11,
    4'd9, 4'd8, 4'd10, 4'd7, 4'd10, 4'd7, 4'd13, 4'd13,
    4'd9, 4'd9, 4'd8, 4'd8, 4'd8, 4'd8, 4'd6, 4'd8,
    4'd8, 4'd4, 4'd6, 4'd8, 4'd4, 4'd12, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8, 4'd10,
    4'd8, 4'd8, 4'd7, 4'd6, 4'd6, 4'd6, 4'd10, 4'd0
  };

  localparam logic [3:0] SMALL_ROM [128] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd7,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3, 4'd3,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5,
    4'd3, 4'd3, 4'd5, 4'd8, 4'd5, 4'd11, 4'd9, 4'd3,
    4'd4, 4'd4, 4'd6, 4'd6, 4'd3, 4'd4, 4'd3, 4'd6,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd3, 4'd3, 4'd7, 4'd6, 4'd7, 4'd6,
    4'd9, 4'd8, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5, 4'd8,
    4'd7, 4'd2, 4'd4, 4'd7, 4'd5, 4'd10, 4'd7, 4'd8,
    4'd6, 4'd8, 4'd7, 4'd6, 4'd6, 4'd6, 4'd8, 4'd12,
    4'd7, 4'd6, 4'd6, 4'd3, 4'd5, 4'd3, 4'd6, 4'd8,
    4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd6,
    4'd6, 4'd2, 4'd3, 4'd5, 4'd2, 4'd10, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd3, 4'd5, 4'd3, 4'd6, 4'd6, 4'd8,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7, 4'd0
  };

  localparam logic [7:0] ACCENT_ROM [AccentCount] = '{
    8'hBC, 8'hA0, 8'hA2, 8'hA9, 8'hA8, 8'hAB, 8'hAA, 8'hAF,
    8'hAE, 8'hB4, 8'hB9, 8'hBB, 8'hA4, 8'hB6, 8'hA7
  };

  function automatic logic [6:0] glyph_code(input logic [7:0] b);
    logic [6:0] c;
    c = b[7] ? CODE_HIGH : b[6:0];
    for (int i = 0; i < AccentCount; i++) begin
      if (b == ACCENT_ROM[i]) begin
        c = 7'(AccentBase + i);
      end
    end
    return c;
  endfunction

endpackage

/* src/tbl_if.sv */
// tbl_if: valid/ready channel interfaces for text bytes and glyph draws
// depends on nothing
interface tbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface tbl_out_if;
  logic               valid;
  logic               ready;
  logic [8:0]         glyph_index;
  logic               glyph_sheet;
  logic signed [15:0] glyph_x;
  logic signed [15:0] glyph_y;
  logic               last_of_run;
  modport source(output valid, glyph_index, glyph_sheet, glyph_x, glyph_y, last_of_run,
                 input ready);
  modport sink(input valid, glyph_index, glyph_sheet, glyph_x, glyph_y, last_of_run,
               output ready);
endinterface

/* src/tbl_regs.sv */
// tbl_regs: apb configuration register file
// depends on tbl_pkg
module tbl_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbl_pkg::AddrWidth-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tbl_pkg::tbl_cfg_t               cfg_o
);

  tbl_pkg::tbl_cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        tbl_pkg::REG_ORIGIN_X:    cfg_d.origin_x = pwdata[15:0];
        tbl_pkg::REG_ORIGIN_Y:    cfg_d.origin_y = pwdata[15:0];
        tbl_pkg::REG_SLANT_DIV:   cfg_d.slant_divisor = pwdata[15:0];
        tbl_pkg::REG_FONT_NUMBER: cfg_d.font_number = pwdata[1:0];
        tbl_pkg::REG_SMALL_FONT:  cfg_d.small_font = pwdata[0];
        tbl_pkg::REG_LINE_HEIGHT: cfg_d.line_height = pwdata[7:0];
        tbl_pkg::REG_PART_FILTER: cfg_d.part_filter = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tbl_pkg::REG_ORIGIN_X:    prdata = {16'h0, cfg_q.origin_x};
      tbl_pkg::REG_ORIGIN_Y:    prdata = {16'h0, cfg_q.origin_y};
      tbl_pkg::REG_SLANT_DIV:   prdata = {16'h0, cfg_q.slant_divisor};
      tbl_pkg::REG_FONT_NUMBER: prdata = {30'h0, cfg_q.font_number};
      tbl_pkg::REG_SMALL_FONT:  prdata = {31'h0, cfg_q.small_font};
      tbl_pkg::REG_LINE_HEIGHT: prdata = {24'h0, cfg_q.line_height};
      tbl_pkg::REG_PART_FILTER: prdata = {27'h0, cfg_q.part_filter};
      default:                  prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{origin_x: 16'sd0, origin_y: 16'sd0, slant_divisor: 16'sd0,
                 font_number: 2'd0, small_font: 1'b0, line_height: 8'd16,
                 part_filter: tbl_pkg::PART_ALL};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/tbl_div.sv */
// tbl_div: iterative signed 24 by 16 divider, one quotient bit per cycle,
// truncating toward zero; depends on nothing
module tbl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] dividend_i,
  input  logic signed [15:0] divisor_i,
  output logic               done_o,
  output logic [15:0]        quot_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] a_q, a_d;
  logic [15:0] rem_q, rem_d, dmag_q, dmag_d;
  logic        neg_q, neg_d;
  logic [16:0] sh;
  logic        ge;

  assign sh = {rem_q, a_q[23]};
  assign ge = sh >= {1'b0, dmag_q};
  assign done_o = done_q;
  assign quot_o = neg_q ? 16'(-a_q) : a_q[15:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    a_d = a_q;
    rem_d = rem_q;
    dmag_d = dmag_q;
    neg_d = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 5'd0;
      a_d = dividend_i[23] ? 24'(-dividend_i) : dividend_i;
      dmag_d = divisor_i[15] ? 16'(-divisor_i) : divisor_i;
      rem_d = 16'd0;
      neg_d = dividend_i[23] ^ divisor_i[15];
    end else if (busy_q) begin
      rem_d = ge ? 16'(sh - {1'b0, dmag_q}) : sh[15:0];
      a_d = {a_q[22:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    rem_q <= rem_d;
    dmag_q <= dmag_d;
    neg_q <= neg_d;
  end

endmodule

/* src/tbl_ctrl.sv */
// tbl_ctrl: sequencing state machine for decode, glyph steps and line end
// depends on tbl_pkg
module tbl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbl_pkg::tbl_sts_t sts_i,
  output tbl_pkg::tbl_cmd_t cmd_o
);

  tbl_pkg::tbl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbl_pkg::ST_IDLE:   if (in_valid_i) state_d = tbl_pkg::ST_DECODE;
      tbl_pkg::ST_DECODE: state_d = sts_i.nonempty ? tbl_pkg::ST_BODY : tbl_pkg::ST_FINISH;
      tbl_pkg::ST_BODY: begin
        if (sts_i.emit) begin
          state_d = tbl_pkg::ST_DIV;
        end else begin
          state_d = sts_i.more ? tbl_pkg::ST_BODY : tbl_pkg::ST_FINISH;
        end
      end
      tbl_pkg::ST_DIV:    if (sts_i.flat || sts_i.div_done) state_d = tbl_pkg::ST_OUT;
      tbl_pkg::ST_OUT: begin
        if (sts_i.out_taken) begin
          state_d = sts_i.more ? tbl_pkg::ST_BODY : tbl_pkg::ST_FINISH;
        end
      end
      tbl_pkg::ST_FINISH: state_d = tbl_pkg::ST_IDLE;
      default:            state_d = tbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tbl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tbl_pkg::ST_DECODE: cmd_o.decode = 1'b1;
      tbl_pkg::ST_BODY: begin
        cmd_o.body = 1'b1;
        cmd_o.div_start = sts_i.emit && !sts_i.flat;
      end
      tbl_pkg::ST_DIV:    cmd_o.load_out = sts_i.flat || sts_i.div_done;
      tbl_pkg::ST_OUT:    cmd_o.advance = sts_i.out_taken;
      tbl_pkg::ST_FINISH: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/tbl_dp.sv */
// tbl_dp: layout datapath: line state, pen, glyph mapping, output register
// depends on tbl_pkg and tbl_div
module tbl_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbl_pkg::tbl_cfg_t  cfg_i,
  input  tbl_pkg::tbl_cmd_t  cmd_i,
  output tbl_pkg::tbl_sts_t  sts_o,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [8:0]         glyph_index_o,
  output logic               glyph_sheet_o,
  output logic signed [15:0] glyph_x_o,
  output logic signed [15:0] glyph_y_o,
  output logic               last_of_run_o
);

  logic [7:0]  byte_q, held_q, held_d, b0_q, b0_d, b1_q, b1_d;
  logic        last_q, open_q, swallow_q, lead_q, has_q;
  tbl_pkg::tbl_phase_e phase_q, nph;
  logic [15:0] pen_q, ly_q;
  logic [23:0] slant_q;
  logic [1:0]  nb_q, nb_d;
  logic        idx_q, el_q, el_d, sk, nsw;
  logic [7:0]  yadd_q, yadd_d;
  logic [6:0]  code_q;
  logic        out_valid_q;
  logic [8:0]  gi_q;
  logic        gs_q, lr_q, glast_q;
  logic [15:0] gx_q, gy_q;

  tbl_pkg::tbl_phase_e ph;
  logic        sw, ld, hs, all, match, flat, emit, more, hs_after;
  logic signed [9:0] hd, pf10;
  logic [7:0]  cur;
  logic [6:0]  cur_code;
  logic signed [4:0] adv;
  logic        div_done;
  logic [15:0] quot;

  assign ph = open_q ? phase_q : tbl_pkg::PH_START;
  assign sw = open_q && swallow_q;
  assign ld = open_q && lead_q;
  assign hs = open_q && has_q;
  assign all = cfg_i.part_filter == tbl_pkg::PART_ALL;
  assign hd = $signed({2'b00, held_q}) - tbl_pkg::CHAR_ZERO;
  assign pf10 = {{5{cfg_i.part_filter[4]}}, cfg_i.part_filter};
  assign match = hd == pf10;
  assign flat = cfg_i.slant_divisor == 16'sd0;

  always_comb begin
    nph = ph;
    nsw = sw;
    held_d = held_q;
    sk = 1'b0;
    nb_d = 2'd0;
    b0_d = byte_q;
    b1_d = byte_q;
    el_d = 1'b0;
    yadd_d = 8'd0;
    if (sw && byte_q == tbl_pkg::CHAR_LF) begin
      nsw = 1'b0;
    end else if (byte_q == tbl_pkg::CHAR_CR || byte_q == tbl_pkg::CHAR_LF) begin
      el_d = 1'b1;
      nsw = byte_q == tbl_pkg::CHAR_CR;
    end else begin
      nsw = 1'b0;
      case (ph)
        tbl_pkg::PH_START: begin
          held_d = byte_q;
          nph = tbl_pkg::PH_HELD;
        end
        tbl_pkg::PH_HELD: begin
          if (byte_q == tbl_pkg::CHAR_BAR) begin
            if (all || match) begin
              sk = 1'b1;
              nph = tbl_pkg::PH_KEEP;
            end else begin
              nph = tbl_pkg::PH_SKIP;
            end
          end else if (all) begin
            sk = 1'b1;
            nph = tbl_pkg::PH_KEEP;
            nb_d = 2'd2;
            b0_d = held_q;
            b1_d = byte_q;
          end else begin
            nph = tbl_pkg::PH_SKIP;
          end
        end
        tbl_pkg::PH_KEEP: nb_d = 2'd1;
        default: ;
      endcase
      el_d = last_q;
    end
    hs_after = (hs && !sk) || (nb_d != 2'd0);
    if (el_d) begin
      case (nph)
        tbl_pkg::PH_START: if (all) yadd_d = {1'b0, cfg_i.line_height[7:1]};
        tbl_pkg::PH_HELD: begin
          if (all) begin
            sk = 1'b1;
            nb_d = 2'd1;
            b0_d = held_d;
            yadd_d = cfg_i.line_height;
          end
        end
        tbl_pkg::PH_KEEP: begin
          yadd_d = hs_after ? cfg_i.line_height : {1'b0, cfg_i.line_height[7:1]};
        end
        default: ;
      endcase
    end
  end

  assign cur = idx_q ? b1_q : b0_q;
  assign emit = lead_q || cur != tbl_pkg::CHAR_LEAD;
  assign more = !idx_q && nb_q == 2'd2;
  assign cur_code = tbl_pkg::glyph_code(cur);
  assign adv = cfg_i.small_font ? $signed({1'b0, tbl_pkg::SMALL_ROM[code_q]})
                                : $signed({1'b0, tbl_pkg::WIDE_ROM[code_q]}) - 5'sd1;

  assign sts_o.nonempty = nb_d != 2'd0;
  assign sts_o.emit = emit;
  assign sts_o.flat = flat;
  assign sts_o.more = more;
  assign sts_o.div_done = div_done;
  assign sts_o.out_taken = out_valid_q && out_ready_i;

  tbl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (slant_q),
    .divisor_i  (cfg_i.slant_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      swallow_q <= 1'b0;
      lead_q <= 1'b0;
      has_q <= 1'b0;
      phase_q <= tbl_pkg::PH_START;
      held_q <= 8'd0;
      pen_q <= 16'd0;
      ly_q <= 16'd0;
      slant_q <= 24'd0;
      nb_q <= 2'd0;
      idx_q <= 1'b0;
      el_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        open_q <= 1'b1;
        if (!open_q) ly_q <= cfg_i.origin_y;
        phase_q <= nph;
        swallow_q <= nsw;
        held_q <= held_d;
        nb_q <= nb_d;
        el_q <= el_d;
        idx_q <= 1'b0;
        if (sk) begin
          pen_q <= cfg_i.origin_x;
          slant_q <= 24'd0;
          lead_q <= 1'b0;
          has_q <= 1'b0;
        end else begin
          lead_q <= ld;
          has_q <= hs;
        end
      end
      if (cmd_i.body) begin
        has_q <= 1'b1;
        lead_q <= !lead_q && cur == tbl_pkg::CHAR_LEAD;
        if (!emit) idx_q <= 1'b1;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      if (cmd_i.advance) begin
        out_valid_q <= 1'b0;
        pen_q <= pen_q + {{11{adv[4]}}, adv};
        slant_q <= slant_q + {{19{adv[4]}}, adv};
        idx_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        ly_q <= ly_q + {8'd0, yadd_q};
        if (el_q || last_q) begin
          phase_q <= tbl_pkg::PH_START;
          lead_q <= 1'b0;
          has_q <= 1'b0;
        end
        if (last_q) begin
          open_q <= 1'b0;
          swallow_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= text_byte_i;
      last_q <= end_of_text_i;
    end
    if (cmd_i.decode) begin
      b0_q <= b0_d;
      b1_q <= b1_d;
      yadd_q <= yadd_d;
    end
    if (cmd_i.body && emit) begin
      code_q <= cur_code;
      glast_q <= !more || b1_q == tbl_pkg::CHAR_LEAD;
    end
    if (cmd_i.load_out) begin
      gs_q <= cfg_i.small_font && flat;
      gi_q <= (cfg_i.small_font && flat) ? {2'b00, code_q} : {cfg_i.font_number, code_q};
      gx_q <= pen_q;
      gy_q <= flat ? ly_q : ly_q + quot;
      lr_q <= glast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign glyph_index_o = gi_q;
  assign glyph_sheet_o = gs_q;
  assign glyph_x_o = gx_q;
  assign glyph_y_o = gy_q;
  assign last_of_run_o = lr_q;

endmodule

/* src/text_block_layout_top.sv */
// text_block_layout_top: one text byte per transaction, 0 to 2 glyph draws out.
// each draw is loaded into the output register; a slanted draw first waits on the
// divider for its quotient, while a flat draw does not start the divider.
// one byte is in work at a time; the next is taken after its draws are taken.
// reset: async active low, registers to defaults, line state cleared, no pass.
module text_block_layout_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tbl_in_if.sink                        in_ch,
  tbl_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbl_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  tbl_pkg::tbl_cfg_t cfg;
  tbl_pkg::tbl_cmd_t cmd;
  tbl_pkg::tbl_sts_t sts;

  tbl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .text_byte_i   (in_ch.text_byte),
    .end_of_text_i (in_ch.end_of_text),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .glyph_index_o (out_ch.glyph_index),
    .glyph_sheet_o (out_ch.glyph_sheet),
    .glyph_x_o     (out_ch.glyph_x),
    .glyph_y_o     (out_ch.glyph_y),
    .last_of_run_o (out_ch.last_of_run)
  );

endmodule
